FILE: design/alm_pkg.sv
// Shared constants, codes and types of the array linked list manager.
`default_nettype none

package alm_pkg;

	localparam int NODES    = 128;
	localparam int DATA_W   = 16;
	localparam int HANDLE_W = 8;
	localparam int IDX_W    = $clog2(NODES);
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;

	// Handle of the sentinel node, which is also the end position.
	localparam logic [HANDLE_W-1:0] SENTINEL = HANDLE_W'(NODES);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_NEXT   = 3'd2,
		OP_PREV   = 3'd3,
		OP_FIRST  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	// One write into a link store.
	typedef struct packed {
		logic                en;
		logic [HANDLE_W-1:0] addr;
		logic [HANDLE_W-1:0] data;
	} link_wr_t;

endpackage

`default_nettype wire

FILE: design/alm_link_ram.sv
// Link store: pool entries in a memory plus the sentinel entry in a register.
`default_nettype none

module alm_link_ram
	import alm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [HANDLE_W-1:0] rd_addr_a,
	input  wire logic [HANDLE_W-1:0] rd_addr_b,
	input  wire link_wr_t            wr,
	output logic      [HANDLE_W-1:0] rd_data_a,
	output logic      [HANDLE_W-1:0] rd_data_b,
	output logic      [HANDLE_W-1:0] sent_link
);

	logic [HANDLE_W-1:0] mem [NODES];
	logic [HANDLE_W-1:0] sent_q;
	logic [HANDLE_W-1:0] raw_a_q;
	logic [HANDLE_W-1:0] raw_b_q;
	logic [HANDLE_W-1:0] hold_a_q;
	logic [HANDLE_W-1:0] hold_b_q;
	logic                use_hold_a_q;
	logic                use_hold_b_q;
	logic                byp_a;
	logic                byp_b;

	assign byp_a = wr.en && (wr.addr == rd_addr_a);
	assign byp_b = wr.en && (wr.addr == rd_addr_b);

	// The sentinel links to itself after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= SENTINEL;
		end else if (wr.en && (wr.addr == SENTINEL)) begin
			sent_q <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.addr != SENTINEL)) begin
			mem[wr.addr[IDX_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_a_q <= mem[rd_addr_a[IDX_W-1:0]];
			raw_b_q <= mem[rd_addr_b[IDX_W-1:0]];
		end
	end

	// A write in the same cycle as the read is forwarded, as is the sentinel.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			hold_a_q     <= byp_a ? wr.data : sent_q;
			hold_b_q     <= byp_b ? wr.data : sent_q;
			use_hold_a_q <= byp_a || (rd_addr_a == SENTINEL);
			use_hold_b_q <= byp_b || (rd_addr_b == SENTINEL);
		end
	end

	assign rd_data_a = use_hold_a_q ? hold_a_q : raw_a_q;
	assign rd_data_b = use_hold_b_q ? hold_b_q : raw_b_q;
	assign sent_link = sent_q;

endmodule

`default_nettype wire

FILE: design/array_linked_list_manager_core.sv
// Top level of the array linked list manager: sequencer, free stack and result register.
`default_nettype none

// An item passes stage one, then stage two, after which the result register raises done.
// Stage one must be empty to take an item; busy is high for the cycle after acceptance.
// This limit comes from the link stores, which take one write a cycle while an insert
// needs two writes into each of them and a delete two into the next links.
// Reset clears the pipeline, free stack top, element count and next-link valid bits
// at once, with no clearing pass; results are never stalled by the receiver.

module array_linked_list_manager_core
	import alm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [HANDLE_W-1:0] position,
	input  wire logic [DATA_W-1:0]   value,
	output logic                     done,
	output logic      [HANDLE_W-1:0] handle,
	output logic      [STATUS_W-1:0] status,
	output logic                     is_empty,
	output logic      [HANDLE_W-1:0] count
);

	// Acceptance and the clamped position. Positions above the sentinel are
	// treated as the sentinel.
	logic                accept;
	logic [HANDLE_W-1:0] pos_in;
	logic [HANDLE_W-1:0] rd_b_addr;

	// Stage one holds the accepted item while the link stores deliver its reads.
	logic                vld_s1;
	logic [OP_W-1:0]     op_s1;
	logic [HANDLE_W-1:0] pos_s1;
	logic [DATA_W-1:0]   value_s1;
	logic [HANDLE_W-1:0] addr_b_s1;
	logic                va_s1;
	logic                vb_s1;

	// Stage two carries the second round of link writes and the result.
	logic                vld_s2;
	logic [HANDLE_W-1:0] hdl_s2;
	status_t             st_s2;
	link_wr_t            nxt_p2_s2;
	link_wr_t            prv_p2_s2;

	// Architectural state held in flip-flops.
	logic [HANDLE_W-1:0] free_top_q;
	logic [HANDLE_W-1:0] count_q;
	logic [NODES-1:0]    nvld_q;

	// Result register.
	logic                done_q;
	logic [HANDLE_W-1:0] handle_q;
	status_t             status_q;
	logic                empty_q;

	// Element data: written on insert, kept for the node's lifetime.
	logic [DATA_W-1:0]   val_mem [NODES];

	// Link store ports.
	link_wr_t            next_wr;
	link_wr_t            prev_wr;
	logic [HANDLE_W-1:0] next_rd_a;
	logic [HANDLE_W-1:0] next_rd_b;
	logic [HANDLE_W-1:0] prev_rd_a;
	logic [HANDLE_W-1:0] next_sent;

	// Stage one decode.
	logic [HANDLE_W-1:0] nxt_a;
	logic [HANDLE_W-1:0] nxt_b;
	link_wr_t            nxt_p1;
	link_wr_t            prv_p1;
	logic                val_we;
	logic [HANDLE_W-1:0] free_top_d;
	logic [HANDLE_W-1:0] count_d;
	logic [HANDLE_W-1:0] hdl_d;
	status_t             st_d;
	link_wr_t            nxt_p2_d;
	link_wr_t            prv_p2_d;
	logic [HANDLE_W-1:0] head_final;

	assign busy   = vld_s1;
	assign accept = start && !vld_s1;
	assign pos_in = (position > SENTINEL) ? SENTINEL : position;

	// The second next-link read fetches the free stack top's successor, or the
	// head of the list when the first element is asked for.
	assign rd_b_addr = (op == OP_FIRST) ? SENTINEL : free_top_q;

	alm_link_ram u_next_links (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (pos_in),
		.rd_addr_b (rd_b_addr),
		.wr        (next_wr),
		.rd_data_a (next_rd_a),
		.rd_data_b (next_rd_b),
		.sent_link (next_sent)
	);

	alm_link_ram u_prev_links (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (pos_in),
		.rd_addr_b (pos_in),
		.wr        (prev_wr),
		.rd_data_a (prev_rd_a),
		.rd_data_b (),
		.sent_link ()
	);

	// A next link that was never written reads as the handle one above its own,
	// which chains the free stack through the pool.
	assign nxt_a = va_s1 ? next_rd_a : pos_s1 + 1'b1;
	assign nxt_b = vb_s1 ? next_rd_b : addr_b_s1 + 1'b1;

	// Decode of the item in stage one. An insert takes the node on top of the
	// free stack, which was read at acceptance as the second next-link address.
	always_comb begin
		nxt_p1     = '0;
		prv_p1     = '0;
		nxt_p2_d   = '0;
		prv_p2_d   = '0;
		val_we     = 1'b0;
		free_top_d = free_top_q;
		count_d    = count_q;
		hdl_d      = pos_s1;
		st_d       = ST_OK;
		case (op_t'(op_s1))
			OP_INSERT: begin
				if (addr_b_s1 == SENTINEL) begin
					hdl_d = SENTINEL;
					st_d  = ST_FULL;
				end else begin
					nxt_p1     = '{en: 1'b1, addr: addr_b_s1, data: pos_s1};
					prv_p1     = '{en: 1'b1, addr: addr_b_s1, data: prev_rd_a};
					nxt_p2_d   = '{en: 1'b1, addr: prev_rd_a, data: addr_b_s1};
					prv_p2_d   = '{en: 1'b1, addr: pos_s1, data: addr_b_s1};
					val_we     = 1'b1;
					free_top_d = nxt_b;
					if (count_q < SENTINEL) begin
						count_d = count_q + 1'b1;
					end
					hdl_d = addr_b_s1;
				end
			end
			OP_DELETE: begin
				if (pos_s1 == SENTINEL) begin
					hdl_d = SENTINEL;
					st_d  = ST_REFUSED;
				end else begin
					nxt_p1     = '{en: 1'b1, addr: prev_rd_a, data: nxt_a};
					prv_p1     = '{en: 1'b1, addr: nxt_a, data: prev_rd_a};
					// The freed node goes on top of the stack and links to the old top.
					nxt_p2_d   = '{en: 1'b1, addr: pos_s1, data: free_top_q};
					free_top_d = pos_s1;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
					hdl_d = nxt_a;
				end
			end
			OP_NEXT: begin
				hdl_d = nxt_a;
			end
			OP_PREV: begin
				hdl_d = prev_rd_a;
			end
			OP_FIRST: begin
				hdl_d = nxt_b;
			end
			default: begin
			end
		endcase
	end

	// Stage one and stage two never hold an item in the same cycle, so each
	// link store sees at most one write a cycle.
	always_comb begin
		if (vld_s1) begin
			next_wr = nxt_p1;
			prev_wr = prv_p1;
		end else begin
			next_wr    = nxt_p2_s2;
			prev_wr    = prv_p2_s2;
			next_wr.en = vld_s2 && nxt_p2_s2.en;
			prev_wr.en = vld_s2 && prv_p2_s2.en;
		end
	end

	// Head of the list once the item's last write has landed.
	assign head_final = (next_wr.en && (next_wr.addr == SENTINEL)) ? next_wr.data : next_sent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			done_q     <= 1'b0;
			free_top_q <= '0;
			count_q    <= '0;
			nvld_q     <= '0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
			if (vld_s1) begin
				free_top_q <= free_top_d;
				count_q    <= count_d;
			end
			if (next_wr.en && (next_wr.addr != SENTINEL)) begin
				nvld_q[next_wr.addr[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// Capture of the accepted item. The valid flags see a write that lands at
	// the same edge, matching the forwarding inside the link stores.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			pos_s1    <= pos_in;
			value_s1  <= value;
			addr_b_s1 <= rd_b_addr;
			va_s1     <= (pos_in == SENTINEL) || nvld_q[pos_in[IDX_W-1:0]]
				|| (next_wr.en && (next_wr.addr == pos_in));
			vb_s1     <= (rd_b_addr == SENTINEL) || nvld_q[rd_b_addr[IDX_W-1:0]]
				|| (next_wr.en && (next_wr.addr == rd_b_addr));
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hdl_s2    <= hdl_d;
			st_s2     <= st_d;
			nxt_p2_s2 <= nxt_p2_d;
			prv_p2_s2 <= prv_p2_d;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && val_we) begin
			val_mem[addr_b_s1[IDX_W-1:0]] <= value_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			handle_q <= hdl_s2;
			status_q <= st_s2;
			empty_q  <= (head_final == SENTINEL);
		end
	end

	assign done     = done_q;
	assign handle   = handle_q;
	assign status   = status_q;
	assign is_empty = empty_q;
	assign count    = count_q;

`ifndef SYNTHESIS
	// The sequencer stays busy for exactly one cycle per item.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> !vld_s1)
		else $error("busy held for more than one cycle");

	// Every accepted item yields its result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted item produced no result");

	// Link writes from the two stages never coincide.
	a_no_stage_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2))
		else $error("both sequencer stages active");

	// A refused or exhausted operation reports the sentinel.
	a_fail_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL || status == ST_REFUSED)) |-> (handle == SENTINEL))
		else $error("failed operation did not return the sentinel");

	// The free stack top and the count stay within the pool.
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_top_q <= SENTINEL) && (count_q <= SENTINEL))
		else $error("free stack top or count out of range");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_array_linked_list_manager_core.sv
// Self-checking testbench for the array linked list manager core.
`timescale 1ns / 1ps

module tb_array_linked_list_manager_core;
	import alm_pkg::*;

	// Largest code that the op port can carry, and largest handle on the position port.
	localparam int OP_CODE_MAX    = (1 << OP_W) - 1;
	localparam int HANDLE_MAX     = (1 << HANDLE_W) - 1;
	// Cycles with neither an item nor a result accepted before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last result for anything stray to appear.
	localparam int TAIL_CYCLES    = 8;

	// How the position of an item is settled when it reaches the ports.
	typedef enum logic [2:0] {
		PICK_FIXED,    // position as written into the item
		PICK_LISTED,   // a node that is on the list, or the sentinel when it is empty
		PICK_NODE,     // any pool node whose previous link has been written
		PICK_ANY,      // any handle, kept off nodes with an unwritten previous link when the op reads it
		PICK_LAST_DEL  // the node that the last successful delete removed
	} pick_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [HANDLE_W-1:0] position;
		logic [DATA_W-1:0]   value;
		pick_t               pick;
		logic [6:0]          gap_pct;
		logic                drain;
	} list_cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [STATUS_W-1:0] status;
		logic                is_empty;
		logic [HANDLE_W-1:0] count;
	} list_answer_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                start    = 1'b0;
	logic [OP_W-1:0]     op       = OP_FIRST;
	logic [HANDLE_W-1:0] position = SENTINEL;
	logic [DATA_W-1:0]   value    = '0;
	logic                busy;
	logic                done;
	logic [HANDLE_W-1:0] handle;
	logic [STATUS_W-1:0] status;
	logic                is_empty;
	logic [HANDLE_W-1:0] count;

	array_linked_list_manager_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.position (position),
		.value    (value),
		.done     (done),
		.handle   (handle),
		.status   (status),
		.is_empty (is_empty),
		.count    (count)
	);

	always #10 clk = ~clk;

	// Shadow copy of the node pool. Node values are never visible at the outputs,
	// so only the links, the free stack top and the element count are kept.
	logic [HANDLE_W-1:0] next_of [0:NODES];
	logic [HANDLE_W-1:0] prev_of [0:NODES];
	logic [HANDLE_W-1:0] free_top;
	logic [HANDLE_W-1:0] elem_count;

	// A previous link that was never written must not be read, so the bench
	// remembers which ones have been written and which nodes those are.
	logic                prev_written [0:NODES];
	logic [HANDLE_W-1:0] linked_once [$];

	// Nodes believed to be on the list. This only steers the stimulus; once
	// stale handles have been used it no longer matches the real links.
	logic [HANDLE_W-1:0] listed_nodes [$];
	logic [HANDLE_W-1:0] last_deleted = SENTINEL;

	list_cmd_t    cmd_queue [$];
	list_answer_t expected_answers [$];
	list_cmd_t    cur_cmd;
	int           gap_now;
	int           n_cmds;
	int           n_accepted    = 0;
	int           results_owed  = 0;
	int           n_errors      = 0;
	int           quiet_cycles  = 0;

	task automatic note_prev_write(input logic [HANDLE_W-1:0] h);
		if (!prev_written[h]) begin
			prev_written[h] = 1'b1;
			if (h != SENTINEL)
				linked_once.push_back(h);
		end
	endtask

	// Applies one accepted item to the shadow pool and works out its result.
	task automatic list_op_predict(input list_cmd_t c, output list_answer_t a);
		logic [HANDLE_W-1:0] pos;
		logic [HANDLE_W-1:0] n;
		logic [HANDLE_W-1:0] s;
		logic [HANDLE_W-1:0] p;
		// Any position above the sentinel means the end position.
		pos      = (c.position > SENTINEL) ? SENTINEL : c.position;
		a.handle = pos;
		a.status = ST_OK;
		case (c.op)
			OP_INSERT: begin
				if (free_top >= SENTINEL) begin
					// Pool exhausted: nothing changes.
					a.handle = SENTINEL;
					a.status = ST_FULL;
				end else begin
					n              = free_top;
					free_top       = next_of[n];
					next_of[n]     = pos;
					prev_of[n]     = prev_of[pos];
					next_of[prev_of[n]] = n;
					prev_of[pos]   = n;
					note_prev_write(n);
					note_prev_write(pos);
					if (elem_count < NODES)
						elem_count = elem_count + 1'b1;
					a.handle = n;
				end
			end
			OP_DELETE: begin
				if (pos == SENTINEL) begin
					a.handle = SENTINEL;
					a.status = ST_REFUSED;
				end else begin
					// The handle is trusted as given, even a free or stale one.
					s          = next_of[pos];
					p          = prev_of[pos];
					prev_of[s] = p;
					next_of[p] = s;
					note_prev_write(s);
					next_of[pos] = free_top;
					free_top     = pos;
					if (elem_count > 0)
						elem_count = elem_count - 1'b1;
					a.handle = s;
				end
			end
			OP_NEXT:  a.handle = next_of[pos];
			OP_PREV:  a.handle = prev_of[pos];
			OP_FIRST: a.handle = next_of[SENTINEL];
			default: ;
		endcase
		a.is_empty = (next_of[SENTINEL] == SENTINEL);
		a.count    = elem_count;
	endtask

	task automatic add_cmd(input logic [OP_W-1:0] c_op, input pick_t c_pick,
			input logic [HANDLE_W-1:0] c_pos, input logic [DATA_W-1:0] c_val,
			input logic c_drain);
		list_cmd_t c;
		c.op       = c_op;
		c.position = c_pos;
		c.value    = c_val;
		c.pick     = c_pick;
		c.gap_pct  = 7'(gap_now);
		c.drain    = c_drain;
		cmd_queue.push_back(c);
	endtask

	// Mostly well-formed list traffic on listed nodes, with a tenth of noise:
	// undefined ops, positions past the sentinel, and reads of arbitrary handles.
	task automatic add_random_cmds(input int n, input int ins_pct, input int del_pct);
		int              r;
		logic [OP_W-1:0] rd_op;
		logic            dr;
		for (int i = 0; i < n; i++) begin
			r     = $urandom_range(99);
			rd_op = OP_NEXT + 3'($urandom_range(2));
			dr    = (i == 0) || ($urandom_range(99) == 0);
			if (r < ins_pct) begin
				if ($urandom_range(7) == 0)
					add_cmd(OP_INSERT, PICK_FIXED, SENTINEL, DATA_W'($urandom), dr);
				else
					add_cmd(OP_INSERT, PICK_LISTED, SENTINEL, DATA_W'($urandom), dr);
			end else if (r < ins_pct + del_pct) begin
				add_cmd(OP_DELETE, PICK_LISTED, SENTINEL, DATA_W'($urandom), dr);
			end else if (r < 90) begin
				add_cmd(rd_op, ($urandom_range(9) < 7) ? PICK_LISTED : PICK_ANY,
					SENTINEL, DATA_W'($urandom), dr);
			end else begin
				case ($urandom_range(3))
					0: add_cmd(OP_W'($urandom_range(OP_FIRST + 1, OP_CODE_MAX)), PICK_FIXED,
						HANDLE_W'($urandom_range(HANDLE_MAX)), DATA_W'($urandom), dr);
					1: add_cmd(OP_INSERT, PICK_FIXED,
						HANDLE_W'($urandom_range(SENTINEL, HANDLE_MAX)), DATA_W'($urandom), dr);
					2: add_cmd(OP_DELETE, PICK_FIXED,
						HANDLE_W'($urandom_range(SENTINEL, HANDLE_MAX)), DATA_W'($urandom), dr);
					default: add_cmd(rd_op, PICK_FIXED,
						HANDLE_W'($urandom_range(SENTINEL + 1, HANDLE_MAX)), DATA_W'($urandom), dr);
				endcase
			end
		end
	endtask

	// Driver. An item is taken at an edge where start is high and busy is low;
	// the prediction is made at that edge, so the shadow pool always reflects
	// every item accepted so far when the position of the next one is settled.
	always @(posedge clk) begin
		list_cmd_t    nxt;
		list_answer_t want;
		logic         took;
		logic         found;
		logic         reads_prev;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			if (took) begin
				list_op_predict(cur_cmd, want);
				expected_answers.push_back(want);
				n_accepted++;
				if (cur_cmd.op == OP_INSERT && want.status == ST_OK)
					listed_nodes.push_back(want.handle);
				if (cur_cmd.op == OP_DELETE && want.status == ST_OK) begin
					last_deleted = cur_cmd.position;
					found = 1'b0;
					for (int k = 0; k < listed_nodes.size() && !found; k++) begin
						if (listed_nodes[k] == cur_cmd.position) begin
							listed_nodes.delete(k);
							found = 1'b1;
						end
					end
				end
			end
			// The strobe is sampled before this edge updates it, so the count of
			// results still owed does not depend on the order of the processes.
			results_owed = results_owed + (took ? 1 : 0) - (done ? 1 : 0);

			if (!(start && busy)) begin
				if (cmd_queue.size() != 0 && !(cmd_queue[0].drain && results_owed != 0)
						&& $urandom_range(99) >= cmd_queue[0].gap_pct) begin
					nxt        = cmd_queue.pop_front();
					reads_prev = (nxt.op == OP_INSERT) || (nxt.op == OP_DELETE) ||
						(nxt.op == OP_PREV);
					case (nxt.pick)
						PICK_LISTED: nxt.position = (listed_nodes.size() != 0) ?
							listed_nodes[$urandom_range(listed_nodes.size() - 1)] : SENTINEL;
						PICK_NODE: nxt.position = (linked_once.size() != 0) ?
							linked_once[$urandom_range(linked_once.size() - 1)] : SENTINEL;
						PICK_ANY: begin
							nxt.position = HANDLE_W'($urandom_range(HANDLE_MAX));
							if (reads_prev && nxt.position < SENTINEL &&
									!prev_written[nxt.position])
								nxt.position = SENTINEL;
						end
						PICK_LAST_DEL: nxt.position = last_deleted;
						default: ;
					endcase
					cur_cmd  = nxt;
					start    <= 1'b1;
					op       <= nxt.op;
					position <= nxt.position;
					value    <= nxt.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		list_answer_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("result with no item outstanding: handle %0d, status %0d", handle, status);
				n_errors++;
			end else begin
				want = expected_answers.pop_front();
				if (handle !== want.handle) begin
					$error("handle: expected %0d, actual %0d", want.handle, handle);
					n_errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					n_errors++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
					n_errors++;
				end
				if (count !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, count);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on progress: any accepted item or result restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_array_linked_list_manager_core failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Shadow pool after reset: pool nodes chained in order into the free
		// stack, the sentinel pointing at itself both ways.
		for (int i = 0; i < NODES; i++) begin
			next_of[i]      = HANDLE_W'(i + 1);
			prev_of[i]      = '0;
			prev_written[i] = 1'b0;
		end
		next_of[NODES]      = SENTINEL;
		prev_of[NODES]      = SENTINEL;
		prev_written[NODES] = 1'b1;
		free_top            = '0;
		elem_count          = '0;

		// Directed part, with the sender idling about a third of the time.
		gap_now = 32;
		add_cmd(OP_FIRST,  PICK_FIXED, '0,       '0, 1'b0);   // empty list
		add_cmd(OP_NEXT,   PICK_FIXED, SENTINEL, '0, 1'b0);
		add_cmd(OP_PREV,   PICK_FIXED, SENTINEL, '0, 1'b0);
		add_cmd(OP_DELETE, PICK_FIXED, SENTINEL, '0, 1'b0);   // refused at the sentinel
		add_cmd(OP_DELETE, PICK_FIXED, HANDLE_W'(HANDLE_MAX), '0, 1'b0);  // clamped, refused
		add_cmd(OP_INSERT, PICK_FIXED, SENTINEL, '0, 1'b0);   // node 0 at the end
		add_cmd(OP_INSERT, PICK_FIXED, HANDLE_W'(200), '1, 1'b0);  // past the end, node 1
		add_cmd(OP_INSERT, PICK_FIXED, '0, 16'h5a5a, 1'b0);   // node 2 before node 0
		add_cmd(OP_FIRST,  PICK_FIXED, HANDLE_W'(HANDLE_MAX), '0, 1'b0);
		add_cmd(OP_NEXT,   PICK_FIXED, HANDLE_W'(2), '0, 1'b0);
		add_cmd(OP_PREV,   PICK_FIXED, '0, '0, 1'b0);
		add_cmd(OP_PREV,   PICK_FIXED, SENTINEL, '0, 1'b0);
		add_cmd(OP_NEXT,   PICK_FIXED, HANDLE_W'(1), '0, 1'b0);
		add_cmd(OP_NEXT,   PICK_FIXED, HANDLE_W'(NODES - 1), '0, 1'b0);  // still in the free chain
		add_cmd(OP_NEXT,   PICK_FIXED, HANDLE_W'(5), '0, 1'b0);
		add_cmd(OP_NEXT,   PICK_FIXED, HANDLE_W'(HANDLE_MAX), '0, 1'b0);
		add_cmd(OP_DELETE, PICK_FIXED, '0, '0, 1'b1);         // middle node, after a pause
		add_cmd(OP_DELETE, PICK_FIXED, HANDLE_W'(2), '0, 1'b0);  // head node
		add_cmd(OP_W'(OP_FIRST + 1), PICK_FIXED, '0, '0, 1'b0);  // undefined ops
		add_cmd(OP_W'(OP_FIRST + 2), PICK_FIXED, HANDLE_W'(HANDLE_MAX), '0, 1'b0);
		add_cmd(OP_W'(OP_CODE_MAX), PICK_FIXED, SENTINEL, '1, 1'b0);
		add_cmd(OP_DELETE, PICK_FIXED, HANDLE_W'(1), '0, 1'b0);  // list empty again
		add_cmd(OP_FIRST,  PICK_FIXED, '0, '0, 1'b0);

		// Random part in three idling phases: a filling stretch that runs the
		// pool dry, a draining stretch, then balanced traffic with no idling.
		add_random_cmds(300, 70, 10);
		gap_now = 53;
		add_random_cmds(300, 15, 65);
		gap_now = 0;
		add_random_cmds(300, 40, 35);

		// Unvalidated handles break the list for good, so they come last. Fill
		// the pool, delete one node twice so that it loops in the free stack,
		// and insert on until the element count saturates at the top.
		for (int i = 0; i < NODES + 4; i++)
			add_cmd(OP_INSERT, PICK_LISTED, SENTINEL, DATA_W'($urandom), i == 0);
		add_cmd(OP_DELETE, PICK_LISTED, SENTINEL, '0, 1'b0);
		add_cmd(OP_DELETE, PICK_LAST_DEL, SENTINEL, '0, 1'b0);
		for (int i = 0; i < 3; i++)
			add_cmd(OP_INSERT, PICK_LISTED, SENTINEL, DATA_W'($urandom), 1'b0);
		for (int i = 0; i < 40; i++)
			add_cmd(OP_W'($urandom_range(OP_CODE_MAX)), PICK_ANY, SENTINEL,
				DATA_W'($urandom), 1'b0);
		// Enough deletes of written nodes to drive the count to zero and past it.
		for (int i = 0; i < NODES + 12; i++)
			add_cmd(OP_DELETE, PICK_NODE, SENTINEL, '0, 1'b0);
		add_cmd(OP_FIRST, PICK_FIXED, '0, '0, 1'b0);
		add_cmd(OP_NEXT,  PICK_FIXED, SENTINEL, '0, 1'b0);
		n_cmds = cmd_queue.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted != n_cmds || expected_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb_array_linked_list_manager_core passed");
		else
			$display("tb_array_linked_list_manager_core failed");
		$finish;
	end

endmodule

FILE: files.f
design/alm_pkg.sv
design/alm_link_ram.sv
design/array_linked_list_manager_core.sv
sim/tb_array_linked_list_manager_core.sv
